@@ hdl/assert_macros.svh @@
// assertion macros shared by the solver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clock, off during reset
`define DLS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("solver check failed");

// condition now implies property on the next clock
`define DLS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("solver check failed");

`endif

@@ hdl/dlsws_pkg.sv @@
// types, constants and saturation helpers of the wrench solver
package dlsws_pkg;

   localparam int WRENCH_DIM = 6;
   localparam int GRAM_SIZE  = 21;
   localparam int ACC_SIZE   = 27;
   localparam int DIV_STEPS  = 48;

   localparam logic [2:0]  LAST_ROW  = 3'(WRENCH_DIM - 1);
   localparam logic [4:0]  GRAM_LAST = 5'(GRAM_SIZE - 1);
   localparam logic [4:0]  ACC_LAST  = 5'(ACC_SIZE - 1);
   localparam logic [4:0]  PROJ_BASE = 5'(GRAM_SIZE);
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   localparam logic signed [63:0] SAT_MAX64 = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] SAT_MIN64 = 64'shffff_ffff_8000_0000;
   localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

   // csr register indexes
   localparam logic CSR_DAMPING = 1'b0;
   localparam logic CSR_GAIN    = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   // accumulator slot to operand rows: gram lower triangle, then projection (row 6 is torque)
   localparam logic [2:0] ACC_ROW [ACC_SIZE] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
   localparam logic [2:0] ACC_COL [ACC_SIZE] = '{
      3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd3,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};

   typedef struct packed {
      logic               start;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [31:0] quot;
      logic               sat;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32_val(input logic signed [63:0] x);
      if (x > SAT_MAX64) return 32'sh7fff_ffff;
      else if (x < SAT_MIN64) return 32'sh8000_0000;
      else return x[31:0];
   endfunction

   function automatic logic sat32_flag(input logic signed [63:0] x);
      return (x > SAT_MAX64) || (x < SAT_MIN64);
   endfunction

   function automatic logic signed [63:0] add_sat64_val(input logic signed [63:0] a,
                                                        input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return INT64_MAX;
      else if (a[63] && b[63] && !s[63]) return INT64_MIN;
      else return s;
   endfunction

   function automatic logic add_sat64_flag(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      return (a[63] == b[63]) && (s[63] != a[63]);
   endfunction

endpackage

@@ hdl/damped_least_squares_wrench_solver.sv @@
// top level: joint accumulation, ldl solve sequencer and per-arm smoothing filter
//
//  channel | direction | handshake            | beat
//  req_    | in        | req_valid/req_ready  | one joint: jacobian column, torque, arm, last
//  rsp_    | out       | rsp_valid/rsp_ready  | filtered wrench, arm id, status
//  csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// every joint runs 27 products through the one shared multiplier, each a multiply then an add step
// a last joint then runs the solve: the 21 serial divisions in the divider unit and the multiply
// steps of factor and substitutions
// reset is synchronous and clears accumulators, filter states and csr registers to zero
// the result sits in an output register, so a stalled rsp_ beat does not block the next joint;
// only a second result waits for the first to be taken
module damped_least_squares_wrench_solver
   import dlsws_pkg::*;
#(
   parameter int FILTER_SETS = 3
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_lin_x,
   input  logic signed [31:0] req_lin_y,
   input  logic signed [31:0] req_lin_z,
   input  logic signed [31:0] req_ang_x,
   input  logic signed [31:0] req_ang_y,
   input  logic signed [31:0] req_ang_z,
   input  logic signed [31:0] req_joint_torque,
   input  logic [1:0]         req_arm_select,
   input  logic               req_last_joint,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic signed [31:0] rsp_torque_x,
   output logic signed [31:0] rsp_torque_y,
   output logic signed [31:0] rsp_torque_z,
   output logic [1:0]         rsp_arm_id,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [20:0]        csr_wdata
);

`include "assert_macros.svh"

   localparam int SET_W = (FILTER_SETS > 1) ? $clog2(FILTER_SETS) : 1;

   typedef enum logic [24:0] {
      ST_IDLE     = 25'b1 << 0,
      ST_ACC_MUL  = 25'b1 << 1,
      ST_ACC_ADD  = 25'b1 << 2,
      ST_LAM_MUL  = 25'b1 << 3,
      ST_LOAD     = 25'b1 << 4,
      ST_FAC_INIT = 25'b1 << 5,
      ST_FAC_M1   = 25'b1 << 6,
      ST_FAC_M2   = 25'b1 << 7,
      ST_FAC_SUB  = 25'b1 << 8,
      ST_FAC_END  = 25'b1 << 9,
      ST_FAC_DIV  = 25'b1 << 10,
      ST_FWD_INIT = 25'b1 << 11,
      ST_FWD_M    = 25'b1 << 12,
      ST_FWD_SUB  = 25'b1 << 13,
      ST_FWD_END  = 25'b1 << 14,
      ST_YDIV_GO  = 25'b1 << 15,
      ST_YDIV_W   = 25'b1 << 16,
      ST_BWD_INIT = 25'b1 << 17,
      ST_BWD_M    = 25'b1 << 18,
      ST_BWD_SUB  = 25'b1 << 19,
      ST_BWD_END  = 25'b1 << 20,
      ST_FLT_M1   = 25'b1 << 21,
      ST_FLT_M2   = 25'b1 << 22,
      ST_FLT_ADD  = 25'b1 << 23,
      ST_OUT      = 25'b1 << 24
   } state_type;

   state_type state_ff, state_in;

   // captured joint: six column rows, then the torque
   logic signed [31:0] item_ff [7];
   logic signed [31:0] item_in [7];
   logic [1:0]         arm_ff, arm_in;
   logic               last_ff, last_in;

   // running sums: gram lower triangle then projected torque
   logic signed [63:0] acc_mem_ff [ACC_SIZE];
   logic signed [63:0] acc_mem_in [ACC_SIZE];
   logic               sat_sticky_ff, sat_sticky_in;

   // factor held in place: l below the diagonal, d on it
   logic signed [31:0] m_ff [WRENCH_DIM][WRENCH_DIM];
   logic signed [31:0] m_in [WRENCH_DIM][WRENCH_DIM];
   // y, then y/d, then the wrench
   logic signed [31:0] vec_ff [WRENCH_DIM];
   logic signed [31:0] vec_in [WRENCH_DIM];
   logic signed [31:0] filt_ff [FILTER_SETS][WRENCH_DIM];
   logic signed [31:0] filt_in [FILTER_SETS][WRENCH_DIM];

   logic signed [63:0] acc64_ff, acc64_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               solve_sat_ff, solve_sat_in;
   logic               sing_ff, sing_in;
   logic [4:0]         idx_ff, idx_in;
   logic [2:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [20:0]        damping_ff, damping_in;
   logic [16:0]        gain_ff, gain_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_w_ff [WRENCH_DIM];
   logic signed [31:0] rsp_w_in [WRENCH_DIM];
   logic [1:0]         rsp_arm_ff, rsp_arm_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic               mul_en;

   logic signed [63:0] mq_wide;
   logic signed [31:0] mq_val;
   logic               mq_sat;
   logic signed [63:0] lam2;
   logic signed [63:0] fsum;
   logic [16:0]        alpha, one_minus;
   logic               arm_ok;
   logic [SET_W-1:0]   set_idx;
   logic               out_load;
   logic signed [63:0] g_tmp;
   logic signed [31:0] r_tmp;

   div_req_type div_req;
   div_rsp_type div_rsp;

   dlsws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign mul_full = mul_a * mul_b;
   // q16 product floor-shifted back, then clipped to 32 bits
   assign mq_wide  = prod_ff >>> 16;
   assign mq_val   = sat32_val(mq_wide);
   assign mq_sat   = sat32_flag(mq_wide);
   assign lam2     = prod_ff >>> 16;
   assign fsum     = (acc64_ff + prod_ff) >>> 16;
   assign alpha    = (gain_ff > ONE_Q16) ? ONE_Q16 : gain_ff;
   assign one_minus = ONE_Q16 - alpha;
   assign arm_ok   = 32'(arm_ff) < FILTER_SETS;
   assign set_idx  = arm_ff[SET_W-1:0];
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      arm_in        = arm_ff;
      last_in       = last_ff;
      acc_mem_in    = acc_mem_ff;
      sat_sticky_in = sat_sticky_ff;
      m_in          = m_ff;
      vec_in        = vec_ff;
      filt_in       = filt_ff;
      acc64_in      = acc64_ff;
      solve_sat_in  = solve_sat_ff;
      sing_in       = sing_ff;
      idx_in        = idx_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      damping_in    = damping_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_arm_in    = rsp_arm_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      mul_en        = 1'b0;
      div_req       = '0;
      g_tmp         = '0;
      r_tmp         = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_DAMPING: damping_in = csr_wdata;
            CSR_GAIN:    gain_in    = csr_wdata[16:0];
            default:     damping_in = damping_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in[0]   = req_lin_x;
               item_in[1]   = req_lin_y;
               item_in[2]   = req_lin_z;
               item_in[3]   = req_ang_x;
               item_in[4]   = req_ang_y;
               item_in[5]   = req_ang_z;
               item_in[6]   = req_joint_torque;
               arm_in       = req_arm_select;
               last_in      = req_last_joint;
               idx_in       = '0;
               sing_in      = 1'b0;
               solve_sat_in = 1'b0;
               state_in     = ST_ACC_MUL;
            end
         end
         ST_ACC_MUL: begin
            mul_en   = 1'b1;
            mul_a    = 33'(item_ff[ACC_ROW[idx_ff]]);
            mul_b    = 33'(item_ff[ACC_COL[idx_ff]]);
            state_in = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            acc_mem_in[idx_ff] = add_sat64_val(acc_mem_ff[idx_ff], mq_wide);
            sat_sticky_in = sat_sticky_ff | add_sat64_flag(acc_mem_ff[idx_ff], mq_wide);
            if (idx_ff == ACC_LAST) begin
               idx_in   = '0;
               state_in = last_ff ? ST_LAM_MUL : ST_IDLE;
            end else begin
               idx_in   = idx_ff + 5'd1;
               state_in = ST_ACC_MUL;
            end
         end
         ST_LAM_MUL: begin
            // damping squared for the diagonal
            mul_en   = 1'b1;
            mul_a    = {12'd0, damping_ff};
            mul_b    = {12'd0, damping_ff};
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            g_tmp = acc_mem_ff[idx_ff];
            if (ACC_ROW[idx_ff] == ACC_COL[idx_ff]) begin
               g_tmp = add_sat64_val(acc_mem_ff[idx_ff], lam2);
               sat_sticky_in = sat_sticky_ff | add_sat64_flag(acc_mem_ff[idx_ff], lam2);
            end
            m_in[ACC_ROW[idx_ff]][ACC_COL[idx_ff]] = sat32_val(g_tmp);
            solve_sat_in = solve_sat_ff | sat32_flag(g_tmp);
            if (idx_ff == GRAM_LAST) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_FAC_INIT;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_FAC_INIT: begin
            acc64_in = 64'(m_ff[i_ff][j_ff]);
            k_in     = '0;
            state_in = (j_ff == '0) ? ST_FAC_END : ST_FAC_M1;
         end
         ST_FAC_M1: begin
            mul_en   = 1'b1;
            mul_a    = 33'(m_ff[i_ff][k_ff]);
            mul_b    = 33'(m_ff[j_ff][k_ff]);
            state_in = ST_FAC_M2;
         end
         ST_FAC_M2: begin
            mul_en       = 1'b1;
            mul_a        = 33'(mq_val);
            mul_b        = 33'(m_ff[k_ff][k_ff]);
            solve_sat_in = solve_sat_ff | mq_sat;
            state_in     = ST_FAC_SUB;
         end
         ST_FAC_SUB: begin
            acc64_in     = acc64_ff - 64'(mq_val);
            solve_sat_in = solve_sat_ff | mq_sat;
            k_in         = k_ff + 3'd1;
            state_in     = (k_ff + 3'd1 == j_ff) ? ST_FAC_END : ST_FAC_M1;
         end
         ST_FAC_END: begin
            r_tmp        = sat32_val(acc64_ff);
            solve_sat_in = solve_sat_ff | sat32_flag(acc64_ff);
            if (i_ff == j_ff) begin
               m_in[j_ff][j_ff] = r_tmp;
               if (r_tmp == '0) begin
                  // zero pivot ends the solve
                  sing_in  = 1'b1;
                  state_in = ST_OUT;
               end else if (j_ff == LAST_ROW) begin
                  i_in     = '0;
                  state_in = ST_FWD_INIT;
               end else begin
                  i_in     = j_ff + 3'd1;
                  state_in = ST_FAC_INIT;
               end
            end else begin
               div_req.start = 1'b1;
               div_req.num   = r_tmp;
               div_req.den   = m_ff[j_ff][j_ff];
               state_in      = ST_FAC_DIV;
            end
         end
         ST_FAC_DIV: begin
            if (div_rsp.done) begin
               m_in[i_ff][j_ff] = div_rsp.quot;
               solve_sat_in     = solve_sat_ff | div_rsp.sat;
               if (i_ff == LAST_ROW) begin
                  j_in = j_ff + 3'd1;
                  i_in = j_ff + 3'd1;
               end else begin
                  i_in = i_ff + 3'd1;
               end
               state_in = ST_FAC_INIT;
            end
         end
         ST_FWD_INIT: begin
            acc64_in     = 64'(sat32_val(acc_mem_ff[PROJ_BASE + {2'd0, i_ff}]));
            solve_sat_in = solve_sat_ff | sat32_flag(acc_mem_ff[PROJ_BASE + {2'd0, i_ff}]);
            k_in         = '0;
            state_in     = (i_ff == '0) ? ST_FWD_END : ST_FWD_M;
         end
         ST_FWD_M: begin
            mul_en   = 1'b1;
            mul_a    = 33'(m_ff[i_ff][k_ff]);
            mul_b    = 33'(vec_ff[k_ff]);
            state_in = ST_FWD_SUB;
         end
         ST_FWD_SUB: begin
            acc64_in     = acc64_ff - 64'(mq_val);
            solve_sat_in = solve_sat_ff | mq_sat;
            k_in         = k_ff + 3'd1;
            state_in     = (k_ff + 3'd1 == i_ff) ? ST_FWD_END : ST_FWD_M;
         end
         ST_FWD_END: begin
            vec_in[i_ff] = sat32_val(acc64_ff);
            solve_sat_in = solve_sat_ff | sat32_flag(acc64_ff);
            if (i_ff == LAST_ROW) begin
               i_in     = '0;
               state_in = ST_YDIV_GO;
            end else begin
               i_in     = i_ff + 3'd1;
               state_in = ST_FWD_INIT;
            end
         end
         ST_YDIV_GO: begin
            div_req.start = 1'b1;
            div_req.num   = vec_ff[i_ff];
            div_req.den   = m_ff[i_ff][i_ff];
            state_in      = ST_YDIV_W;
         end
         ST_YDIV_W: begin
            if (div_rsp.done) begin
               vec_in[i_ff] = div_rsp.quot;
               solve_sat_in = solve_sat_ff | div_rsp.sat;
               if (i_ff == LAST_ROW) begin
                  state_in = ST_BWD_INIT;
               end else begin
                  i_in     = i_ff + 3'd1;
                  state_in = ST_YDIV_GO;
               end
            end
         end
         ST_BWD_INIT: begin
            acc64_in = 64'(vec_ff[i_ff]);
            k_in     = i_ff + 3'd1;
            state_in = (i_ff == LAST_ROW) ? ST_BWD_END : ST_BWD_M;
         end
         ST_BWD_M: begin
            mul_en   = 1'b1;
            mul_a    = 33'(m_ff[k_ff][i_ff]);
            mul_b    = 33'(vec_ff[k_ff]);
            state_in = ST_BWD_SUB;
         end
         ST_BWD_SUB: begin
            acc64_in     = acc64_ff - 64'(mq_val);
            solve_sat_in = solve_sat_ff | mq_sat;
            if (k_ff == LAST_ROW) begin
               state_in = ST_BWD_END;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_BWD_M;
            end
         end
         ST_BWD_END: begin
            vec_in[i_ff] = sat32_val(acc64_ff);
            solve_sat_in = solve_sat_ff | sat32_flag(acc64_ff);
            if (i_ff == '0) begin
               state_in = (alpha != '0 && arm_ok) ? ST_FLT_M1 : ST_OUT;
            end else begin
               i_in     = i_ff - 3'd1;
               state_in = ST_BWD_INIT;
            end
         end
         ST_FLT_M1: begin
            mul_en   = 1'b1;
            mul_a    = {16'd0, one_minus};
            mul_b    = 33'(filt_ff[set_idx][i_ff]);
            state_in = ST_FLT_M2;
         end
         ST_FLT_M2: begin
            mul_en   = 1'b1;
            acc64_in = prod_ff;
            mul_a    = {16'd0, alpha};
            mul_b    = 33'(vec_ff[i_ff]);
            state_in = ST_FLT_ADD;
         end
         ST_FLT_ADD: begin
            // blend never leaves the 32-bit range, status is already settled
            filt_in[set_idx][i_ff] = sat32_val(fsum);
            vec_in[i_ff]           = sat32_val(fsum);
            if (i_ff == LAST_ROW) begin
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff + 3'd1;
               state_in = ST_FLT_M1;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_arm_in   = arm_ff;
               for (int n = 0; n < WRENCH_DIM; n++) begin
                  rsp_w_in[n] = sing_ff ? 32'sd0 : vec_ff[n];
               end
               if (sing_ff) begin
                  rsp_status_in = STATUS_SINGULAR;
               end else if (solve_sat_ff || sat_sticky_ff) begin
                  rsp_status_in = STATUS_SAT;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               // fresh set of sums for the next arm pass
               for (int n = 0; n < ACC_SIZE; n++) begin
                  acc_mem_in[n] = '0;
               end
               sat_sticky_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign prod_in = mul_en ? mul_full[63:0] : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sat_sticky_ff <= 1'b0;
         damping_ff    <= '0;
         gain_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         sing_ff       <= 1'b0;
         solve_sat_ff  <= 1'b0;
         for (int n = 0; n < ACC_SIZE; n++) begin
            acc_mem_ff[n] <= '0;
         end
         for (int s = 0; s < FILTER_SETS; s++) begin
            for (int n = 0; n < WRENCH_DIM; n++) begin
               filt_ff[s][n] <= '0;
            end
         end
      end else begin
         state_ff      <= state_in;
         sat_sticky_ff <= sat_sticky_in;
         damping_ff    <= damping_in;
         gain_ff       <= gain_in;
         rsp_valid_ff  <= rsp_valid_in;
         sing_ff       <= sing_in;
         solve_sat_ff  <= solve_sat_in;
         acc_mem_ff    <= acc_mem_in;
         filt_ff       <= filt_in;
      end
      item_ff       <= item_in;
      arm_ff        <= arm_in;
      last_ff       <= last_in;
      m_ff          <= m_in;
      vec_ff        <= vec_in;
      acc64_ff      <= acc64_in;
      prod_ff       <= prod_in;
      idx_ff        <= idx_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_arm_ff    <= rsp_arm_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_force_x  = rsp_w_ff[0];
   assign rsp_force_y  = rsp_w_ff[1];
   assign rsp_force_z  = rsp_w_ff[2];
   assign rsp_torque_x = rsp_w_ff[3];
   assign rsp_torque_y = rsp_w_ff[4];
   assign rsp_torque_z = rsp_w_ff[5];
   assign rsp_arm_id   = rsp_arm_ff;
   assign rsp_status   = rsp_status_ff;

   // singular beat carries a zero wrench
   `DLS_ASSERT(a_sing_zero, (rsp_valid_ff && rsp_status_ff == STATUS_SINGULAR) |-> (rsp_w_ff[0] == '0 && rsp_w_ff[3] == '0 && rsp_w_ff[5] == '0))
   // divider is only started while idle
   `DLS_ASSERT(a_div_idle, div_req.start |-> !div_rsp.busy)
   // no division left running when a new joint may come in
   `DLS_ASSERT(a_ready_div, req_ready |-> !div_rsp.busy)
   // sums and sticky flag start clean after each result
   `DLS_ASSERT_NEXT(a_acc_clear, out_load, acc_mem_ff[0] == '0 && acc_mem_ff[26] == '0 && !sat_sticky_ff)

endmodule

@@ hdl/dlsws_div.sv @@
// bit-serial signed q16 divider, quotient (num * 65536) / den truncated and saturated
module dlsws_div
   import dlsws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] rem_ff, rem_in;
   logic signed [31:0] quot_ff, quot_in;
   logic        sat_ff, sat_in;

   logic [32:0] rem_sh;
   logic [31:0] num_mag, den_mag;
   logic        fit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      num_mag = req.num[31] ? (~req.num + 32'd1) : req.num;
      den_mag = req.den[31] ? (~req.den + 32'd1) : req.den;
      rem_sh  = {rem_ff, dvd_ff[47]};
      fit     = rem_sh >= {1'b0, dvs_ff};
      if (!busy_ff && req.start) begin
         busy_in = 1'b1;
         neg_in  = req.num[31] ^ req.den[31];
         dvd_in  = {num_mag, 16'd0};
         dvs_in  = den_mag;
         rem_in  = '0;
         cnt_in  = 6'(DIV_STEPS);
      end else if (busy_ff && cnt_ff != '0) begin
         // one quotient bit a cycle, restoring
         rem_in = fit ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         dvd_in = {dvd_ff[46:0], fit};
         cnt_in = cnt_ff - 6'd1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         if (neg_ff) begin
            sat_in  = dvd_ff > 48'h0000_8000_0000;
            quot_in = sat_in ? 32'sh8000_0000 : (~dvd_ff[31:0] + 32'd1);
         end else begin
            sat_in  = dvd_ff > 48'h0000_7fff_ffff;
            quot_in = sat_in ? 32'sh7fff_ffff : dvd_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.sat  = sat_ff;

endmodule
